FILE: sv/irt_pkg.sv
package irt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int ID_W        = 16;
  localparam int MODE_W      = 3;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [MODE_W-1:0] MODE_ADD_LINK    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_NEURON  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FIND_LINK   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIND_NRN_IN = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND_NRN_ID = 3'd4;

  localparam logic KIND_LINK   = 1'b0;
  localparam logic KIND_NEURON = 1'b1;

  // Register index, taken from paddr bit 2 (byte address 4*i).
  localparam logic REG_INNOVATION_START = 1'b0;
  localparam logic REG_NEURON_ID_START  = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   source_neuron;
    logic [ID_W-1:0]   dest_neuron;
  } irt_in_t;

  typedef struct packed {
    logic [ID_W-1:0]  result_id;
    logic             found;
    logic             table_full;
    logic [CNT_W-1:0] link_entries;
    logic [CNT_W-1:0] neuron_entries;
    logic [ID_W-1:0]  next_innovation;
    logic [ID_W-1:0]  current_neuron;
  } irt_out_t;

  typedef struct packed {
    logic [ID_W-1:0] src;
    logic [ID_W-1:0] dst;
    logic [ID_W-1:0] nid;
    logic            kind;
  } irt_entry_t;

  typedef struct packed {
    logic            inn_we;
    logic            nid_we;
    logic [ID_W-1:0] value;
  } irt_cfg_wr_t;

endpackage

FILE: sv/irt_entry_mem.sv
module irt_entry_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [irt_pkg::ADDR_W-1:0]  wr_addr,
  input  irt_pkg::irt_entry_t         wr_data,
  input  logic                        rd_en,
  input  logic [irt_pkg::ADDR_W-1:0]  rd_addr,
  output irt_pkg::irt_entry_t         rd_data
);
  import irt_pkg::*;

  irt_entry_t mem [TABLE_DEPTH];
  irt_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/irt_engine.sv
module irt_engine (
  input  logic                   clk,
  input  logic                   rst_n,
  input  irt_pkg::irt_cfg_wr_t   cfg_wr,
  input  logic [irt_pkg::ID_W-1:0] innovation_start,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  irt_pkg::irt_in_t       in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output irt_pkg::irt_out_t      out_data
);
  import irt_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;

  logic [1:0]        state_r, state_nxt;
  irt_in_t           op_r, op_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [ADDR_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]  entry_total_r, entry_total_nxt;
  logic [CNT_W-1:0]  link_total_r, link_total_nxt;
  logic [CNT_W-1:0]  neuron_total_r, neuron_total_nxt;
  logic [ID_W-1:0]   inn_ctr_r, inn_ctr_nxt;
  logic [ID_W-1:0]   nrn_ctr_r, nrn_ctr_nxt;
  logic              out_valid_r, out_valid_nxt;
  irt_out_t          out_data_r, out_data_nxt;

  logic              mem_we;
  irt_entry_t        mem_wdata;
  logic              mem_re;
  irt_entry_t        mem_rdata;

  logic              out_free;
  logic              room;
  logic              issue_ok;
  logic              match;
  logic              want_kind;
  logic              load_out;
  logic [ID_W-1:0]   res_id;
  logic              res_found;
  logic              res_full;
  logic [ID_W-1:0]   link_max;

  irt_entry_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (entry_total_r[ADDR_W-1:0]),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (scan_r[ADDR_W-1:0]),
    .rd_data (mem_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign room     = entry_total_r < CNT_W'(TABLE_DEPTH);
  assign issue_ok = scan_r < entry_total_r;
  assign want_kind = (op_r.mode == MODE_FIND_LINK) ? KIND_LINK : KIND_NEURON;
  assign match    = (mem_rdata.kind == want_kind) &&
                    (mem_rdata.src == op_r.source_neuron) &&
                    (mem_rdata.dst == op_r.dest_neuron);

  always_comb begin
    link_max = nrn_ctr_r;
    if (in_data.source_neuron > link_max) begin
      link_max = in_data.source_neuron;
    end
    if (in_data.dest_neuron > link_max) begin
      link_max = in_data.dest_neuron;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    op_nxt           = op_r;
    scan_nxt         = scan_r;
    cmp_vld_nxt      = cmp_vld_r;
    cmp_idx_nxt      = cmp_idx_r;
    entry_total_nxt  = entry_total_r;
    link_total_nxt   = link_total_r;
    neuron_total_nxt = neuron_total_r;
    inn_ctr_nxt      = inn_ctr_r;
    nrn_ctr_nxt      = nrn_ctr_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;
    mem_we           = 1'b0;
    mem_wdata        = '0;
    mem_re           = 1'b0;
    load_out         = 1'b0;
    res_id           = '0;
    res_found        = 1'b0;
    res_full         = 1'b0;
    in_stall         = (state_r != ST_IDLE) || !out_free;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr.inn_we) begin
      entry_total_nxt  = '0;
      link_total_nxt   = '0;
      neuron_total_nxt = '0;
      inn_ctr_nxt      = cfg_wr.value;
    end
    if (cfg_wr.nid_we) begin
      nrn_ctr_nxt = cfg_wr.value;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && out_free) begin
          case (in_data.mode) inside
            MODE_ADD_LINK, MODE_ADD_NEURON: begin
              load_out = 1'b1;
              if (!room) begin
                res_full = 1'b1;
              end else begin
                mem_we          = 1'b1;
                mem_wdata.src   = in_data.source_neuron;
                mem_wdata.dst   = in_data.dest_neuron;
                entry_total_nxt = entry_total_r + 1'b1;
                inn_ctr_nxt     = inn_ctr_r + 1'b1;
                res_found       = 1'b1;
                if (in_data.mode == MODE_ADD_LINK) begin
                  mem_wdata.kind = KIND_LINK;
                  mem_wdata.nid  = '0;
                  nrn_ctr_nxt    = link_max;
                  link_total_nxt = link_total_r + 1'b1;
                  res_id         = inn_ctr_r;
                end else begin
                  nrn_ctr_nxt      = nrn_ctr_r + 1'b1;
                  mem_wdata.kind   = KIND_NEURON;
                  mem_wdata.nid    = nrn_ctr_nxt;
                  neuron_total_nxt = neuron_total_r + 1'b1;
                  res_id           = nrn_ctr_nxt;
                end
              end
            end
            MODE_FIND_LINK, MODE_FIND_NRN_IN, MODE_FIND_NRN_ID: begin
              op_nxt      = in_data;
              scan_nxt    = '0;
              cmp_vld_nxt = 1'b0;
              state_nxt   = ST_SEARCH;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // Reads run one entry ahead of the compare; everything freezes while
        // the previous result still waits at the output.
        if (out_free) begin
          if (cmp_vld_r && match) begin
            load_out  = 1'b1;
            res_found = 1'b1;
            if (op_r.mode == MODE_FIND_NRN_ID) begin
              res_id = mem_rdata.nid;
            end else begin
              res_id = innovation_start + ID_W'(cmp_idx_r);
            end
            state_nxt = ST_IDLE;
          end else if (!issue_ok) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            mem_re      = 1'b1;
            scan_nxt    = scan_r + 1'b1;
            cmp_vld_nxt = 1'b1;
            cmp_idx_nxt = scan_r[ADDR_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load_out) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.result_id       = res_id;
      out_data_nxt.found           = res_found;
      out_data_nxt.table_full      = res_full;
      out_data_nxt.link_entries    = link_total_nxt;
      out_data_nxt.neuron_entries  = neuron_total_nxt;
      out_data_nxt.next_innovation = inn_ctr_nxt;
      out_data_nxt.current_neuron  = nrn_ctr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cmp_vld_r      <= 1'b0;
      entry_total_r  <= '0;
      link_total_r   <= '0;
      neuron_total_r <= '0;
      inn_ctr_r      <= '0;
      nrn_ctr_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cmp_vld_r      <= cmp_vld_nxt;
      entry_total_r  <= entry_total_nxt;
      link_total_r   <= link_total_nxt;
      neuron_total_r <= neuron_total_nxt;
      inn_ctr_r      <= inn_ctr_nxt;
      nrn_ctr_r      <= nrn_ctr_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/innovation_record_table.sv
// Innovation record table: an append-only store of up to 256 structural
// innovations (links and neurons), kept in one single-port-read entry memory.
// For an insert (add link, add neuron) and an unused mode the result is
// registered at the edge that takes the transaction. A search reads the memory
// in insertion order, one entry per cycle while the output is free, and compares
// each entry in the cycle after its read; it ends at the first match, or as a
// miss once every entry has been read and compared.
// The engine works on one transaction at a time; a new one is taken while the
// previous result waits, as long as that result leaves in the same cycle.
// Writing innovation_start empties the table. Configuration must be written
// only while the block is idle; the block itself does not enforce this.
module innovation_record_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [irt_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [irt_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [irt_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  irt_pkg::irt_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output irt_pkg::irt_out_t               out_data
);
  import irt_pkg::*;

  logic [ID_W-1:0] inn_start_r, inn_start_nxt;
  logic [ID_W-1:0] nid_start_r, nid_start_nxt;
  logic            wr_fire;
  logic            reg_sel;
  irt_cfg_wr_t     cfg_wr;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    cfg_wr.inn_we = wr_fire && (reg_sel == REG_INNOVATION_START);
    cfg_wr.nid_we = wr_fire && (reg_sel == REG_NEURON_ID_START);
    cfg_wr.value  = pwdata[ID_W-1:0];
    inn_start_nxt = cfg_wr.inn_we ? cfg_wr.value : inn_start_r;
    nid_start_nxt = cfg_wr.nid_we ? cfg_wr.value : nid_start_r;
  end

  always_comb begin
    unique case (reg_sel)
      REG_INNOVATION_START: prdata = APB_DATA_W'(inn_start_r);
      REG_NEURON_ID_START:  prdata = APB_DATA_W'(nid_start_r);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inn_start_r <= '0;
      nid_start_r <= '0;
    end else begin
      inn_start_r <= inn_start_nxt;
      nid_start_r <= nid_start_nxt;
    end
  end

  irt_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr           (cfg_wr),
    .innovation_start (inn_start_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule

FILE: tb/sv/tb_innovation_record_table.sv
`timescale 1ns / 100ps

import irt_pkg::*;

// Scoreboard: keeps its own copy of the table and counters, predicts the result of
// every accepted transaction and compares the results in order.
class innovation_scoreboard;
  irt_entry_t      entries [TABLE_DEPTH];
  int unsigned     entry_count;
  int unsigned     link_count;
  int unsigned     neuron_count;
  logic [ID_W-1:0] innovation_base;
  logic [ID_W-1:0] innovation_next;
  logic [ID_W-1:0] neuron_now;
  irt_out_t        expected_q [$];
  int unsigned     mismatches;

  function new();
    entry_count     = 0;
    link_count      = 0;
    neuron_count    = 0;
    innovation_base = '0;
    innovation_next = '0;
    neuron_now      = '0;
    mismatches      = 0;
  endfunction

  function void write_reg(logic reg_idx, logic [ID_W-1:0] value);
    if (reg_idx == REG_INNOVATION_START) begin
      innovation_base = value;
      innovation_next = value;
      entry_count     = 0;
      link_count      = 0;
      neuron_count    = 0;
    end else begin
      neuron_now = value;
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void note_input(irt_in_t item);
    irt_out_t        want;
    logic [ID_W-1:0] top;
    logic            kind;
    int unsigned     pos;
    want = '0;
    case (item.mode) inside
      MODE_ADD_LINK, MODE_ADD_NEURON: begin
        if (entry_count == TABLE_DEPTH) begin
          want.table_full = 1'b1;
        end else begin
          if (item.mode == MODE_ADD_LINK) begin
            top = neuron_now;
            if (item.source_neuron > top) top = item.source_neuron;
            if (item.dest_neuron > top) top = item.dest_neuron;
            neuron_now     = top;
            want.result_id = innovation_next;
            kind           = KIND_LINK;
            link_count++;
          end else begin
            neuron_now     = neuron_now + 1'b1;
            want.result_id = neuron_now;
            kind           = KIND_NEURON;
            neuron_count++;
          end
          entries[entry_count].src  = item.source_neuron;
          entries[entry_count].dst  = item.dest_neuron;
          entries[entry_count].nid  = (kind == KIND_NEURON) ? neuron_now : '0;
          entries[entry_count].kind = kind;
          entry_count++;
          innovation_next = innovation_next + 1'b1;
          want.found      = 1'b1;
        end
      end
      MODE_FIND_LINK, MODE_FIND_NRN_IN, MODE_FIND_NRN_ID: begin
        kind = (item.mode == MODE_FIND_LINK) ? KIND_LINK : KIND_NEURON;
        // The first match in insertion order wins.
        for (pos = 0; pos < entry_count && !want.found; pos++) begin
          if (entries[pos].kind == kind && entries[pos].src == item.source_neuron &&
              entries[pos].dst == item.dest_neuron) begin
            want.found     = 1'b1;
            want.result_id = (item.mode == MODE_FIND_NRN_ID) ? entries[pos].nid
                                                             : ID_W'(innovation_base + pos);
          end
        end
      end
      default: ;
    endcase
    want.link_entries    = CNT_W'(link_count);
    want.neuron_entries  = CNT_W'(neuron_count);
    want.next_innovation = innovation_next;
    want.current_neuron  = neuron_now;
    expected_q.push_back(want);
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task check_result(irt_out_t got);
    irt_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result %h arrived with nothing outstanding", got));
    end else begin
      want = expected_q.pop_front();
      if (got.result_id !== want.result_id)
        report_mismatch($sformatf("result_id got %h want %h", got.result_id, want.result_id));
      if (got.found !== want.found)
        report_mismatch($sformatf("found got %b want %b", got.found, want.found));
      if (got.table_full !== want.table_full)
        report_mismatch($sformatf("table_full got %b want %b", got.table_full,
                                  want.table_full));
      if (got.link_entries !== want.link_entries)
        report_mismatch($sformatf("link_entries got %0d want %0d", got.link_entries,
                                  want.link_entries));
      if (got.neuron_entries !== want.neuron_entries)
        report_mismatch($sformatf("neuron_entries got %0d want %0d", got.neuron_entries,
                                  want.neuron_entries));
      if (got.next_innovation !== want.next_innovation)
        report_mismatch($sformatf("next_innovation got %h want %h", got.next_innovation,
                                  want.next_innovation));
      if (got.current_neuron !== want.current_neuron)
        report_mismatch($sformatf("current_neuron got %h want %h", got.current_neuron,
                                  want.current_neuron));
    end
  endtask
endclass

module tb_innovation_record_table;

  localparam logic [MODE_W-1:0] MODE_FIRST_UNUSED = 3'd5;
  localparam int QUIET_LIMIT    = 5000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 300;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  irt_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  irt_out_t              out_data;

  innovation_scoreboard sb = new();
  int unsigned tx_idle_pct  = 35;
  int unsigned rx_idle_pct  = 35;
  bit          rx_hold_req  = 1'b0;
  int unsigned quiet_cycles = 0;

  innovation_record_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both channels are sampled at the edge; the scoreboard sees transactions in order.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("[%0t] no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, and a long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] src,
                           input logic [ID_W-1:0] dst);
    irt_in_t item;
    item.mode          = mode;
    item.source_neuron = src;
    item.dest_neuron   = dst;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  // The last transaction is noted by the monitor at the same edge, so the
  // outstanding count is only read from the next edge on.
  task automatic stop_and_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_idx, input logic [ID_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {{(APB_DATA_W - ID_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(reg_idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly ids from a small pool or copied from stored entries so that searches hit
  // and duplicates pile up; the rest are full-range ids.
  task automatic run_items(input int count, input int unsigned insert_pct);
    irt_in_t     item;
    irt_entry_t  seen;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < insert_pct) begin
        item.mode = ($urandom_range(99) < 60) ? MODE_ADD_LINK : MODE_ADD_NEURON;
      end else if (pick < 96) begin
        case ($urandom_range(2))
          0:       item.mode = MODE_FIND_LINK;
          1:       item.mode = MODE_FIND_NRN_IN;
          default: item.mode = MODE_FIND_NRN_ID;
        endcase
      end else begin
        item.mode = MODE_FIRST_UNUSED + MODE_W'($urandom_range(2));
      end
      pick = $urandom_range(99);
      if (pick < 45) begin
        item.source_neuron = ID_W'($urandom_range(7));
        item.dest_neuron   = ID_W'($urandom_range(7));
      end else if (pick < 80 && sb.entry_count != 0) begin
        seen               = sb.entries[$urandom_range(sb.entry_count - 1)];
        item.source_neuron = seen.src;
        item.dest_neuron   = seen.dst;
      end else begin
        item.source_neuron = ID_W'($urandom);
        item.dest_neuron   = ID_W'($urandom);
      end
      send_item(item.mode, item.source_neuron, item.dest_neuron);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: searches on an empty table, extreme ids, neuron counter wrap,
    // first-match on duplicates, kind mismatch, swapped ids and unused modes.
    send_item(MODE_FIND_LINK, 16'h0000, 16'h0000);
    send_item(MODE_FIND_NRN_IN, 16'h0000, 16'h0000);
    send_item(MODE_FIND_NRN_ID, 16'h0000, 16'h0000);
    send_item(MODE_ADD_LINK, 16'hFFFF, 16'h0000);
    send_item(MODE_ADD_LINK, 16'h0000, 16'hFFFF);
    send_item(MODE_ADD_NEURON, 16'hFFFF, 16'h0000);
    send_item(MODE_ADD_NEURON, 16'h1234, 16'h5678);
    send_item(MODE_ADD_LINK, 16'hFFFF, 16'h0000);
    send_item(MODE_FIND_LINK, 16'hFFFF, 16'h0000);
    send_item(MODE_FIND_NRN_IN, 16'hFFFF, 16'h0000);
    send_item(MODE_FIND_NRN_ID, 16'hFFFF, 16'h0000);
    send_item(MODE_FIND_NRN_ID, 16'h1234, 16'h5678);
    send_item(MODE_FIND_LINK, 16'h1234, 16'h5678);
    send_item(MODE_FIND_NRN_ID, 16'h0000, 16'hFFFF);
    send_item(MODE_FIND_NRN_IN, 16'h0000, 16'hFFFF);
    for (int k = 0; k < 3; k++) send_item(MODE_FIRST_UNUSED + MODE_W'(k), 16'hFFFF, 16'hFFFF);
    send_item(MODE_ADD_LINK, 16'hAAAA, 16'h5555);
    send_item(MODE_FIND_LINK, 16'h5555, 16'hAAAA);
    send_item(MODE_FIND_LINK, 16'hAAAA, 16'h5555);
    send_item(MODE_ADD_NEURON, 16'h0000, 16'h0000);
    stop_and_drain();

    // Insert-heavy: innovation numbers wrap and the table fills up; the sender
    // pauses once halfway until everything has come back.
    apb_write(REG_INNOVATION_START, 16'hFFFF);
    apb_write(REG_NEURON_ID_START, 16'hFFF0);
    run_items(150, 80);
    stop_and_drain();
    run_items(190, 80);
    stop_and_drain();

    // A stretch with no idling on either side, then a long hold-off of the results.
    apb_write(REG_INNOVATION_START, ID_W'($urandom));
    apb_write(REG_NEURON_ID_START, 16'h0000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_items(100, 40);
    tx_idle_pct = 35;
    rx_idle_pct = 35;
    rx_hold_req = 1'b1;
    run_items(200, 40);
    stop_and_drain();

    // Search-heavy; the neuron counter is reloaded mid-way without clearing the table.
    apb_write(REG_INNOVATION_START, 16'h0000);
    apb_write(REG_NEURON_ID_START, 16'hFFFF);
    run_items(110, 30);
    stop_and_drain();
    apb_write(REG_NEURON_ID_START, ID_W'($urandom));
    run_items(100, 30);
    stop_and_drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
